FILE: hdl/hsv_pkg.sv
package hsv_pkg;

  localparam int unsigned RGB_W = 8;
  localparam int unsigned HUE_W = 13;
  localparam int unsigned SAT_W = 13;
  localparam int unsigned QUO_W = 13;
  localparam int unsigned REM_W = 20;
  localparam int unsigned SAT_SHIFT = 12;

  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [9:0] HUE_SEXTANT = 10'd960;
  localparam logic [HUE_W-1:0] HUE_CIRCLE = 13'd5760;
  localparam logic [HUE_W-1:0] HUE_RED_BASE = 13'd0;
  localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 13'd1920;
  localparam logic [HUE_W-1:0] HUE_BLUE_BASE = 13'd3840;

  typedef struct packed {
    logic [REM_W-1:0] hue_rem;
    logic [RGB_W-1:0] hue_den;
    logic [QUO_W-1:0] hue_quo;
    logic             hue_neg;
    logic [HUE_W-1:0] hue_base;
    logic [REM_W-1:0] sat_rem;
    logic [RGB_W-1:0] sat_den;
    logic [QUO_W-1:0] sat_quo;
    logic [RGB_W-1:0] value;
  } hsv_cell_t;

endpackage

FILE: hdl/hsv_front.sv
module hsv_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [hsv_pkg::RGB_W-1:0] red_i,
  input  logic [hsv_pkg::RGB_W-1:0] green_i,
  input  logic [hsv_pkg::RGB_W-1:0] blue_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output hsv_pkg::hsv_cell_t        data_o
);
  import hsv_pkg::*;

  logic             valid_q, valid_d;
  hsv_cell_t        data_q, data_d;
  logic [RGB_W-1:0] mx, mn, d, mag;
  logic             neg;
  logic [17:0]      hue_num;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    d = mx - mn;

    data_d = '0;
    // ties go to red first, then green
    if (mx == red_i) begin
      neg = green_i < blue_i;
      mag = neg ? blue_i - green_i : green_i - blue_i;
      data_d.hue_base = neg ? HUE_CIRCLE : HUE_RED_BASE;
    end else if (mx == green_i) begin
      neg = blue_i < red_i;
      mag = neg ? red_i - blue_i : blue_i - red_i;
      data_d.hue_base = HUE_GREEN_BASE;
    end else begin
      neg = red_i < green_i;
      mag = neg ? green_i - red_i : red_i - green_i;
      data_d.hue_base = HUE_BLUE_BASE;
    end

    hue_num = 18'(mag) * 18'(HUE_SEXTANT);
    data_d.hue_rem = REM_W'(hue_num);
    data_d.hue_den = (d == '0) ? RGB_W'(1) : d;
    data_d.hue_neg = neg;
    data_d.sat_rem = REM_W'(d) << SAT_SHIFT;
    data_d.sat_den = (mx == '0) ? RGB_W'(1) : mx;
    data_d.value = mx;

    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

FILE: hdl/hsv_div_cell.sv
module hsv_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  hsv_pkg::hsv_cell_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output hsv_pkg::hsv_cell_t data_o
);
  import hsv_pkg::*;

  logic             valid_q, valid_d;
  hsv_cell_t        data_q, data_d;
  logic [REM_W-1:0] hue_div, sat_div;

  assign ready_o = !valid_q || ready_i;
  assign hue_div = REM_W'(data_i.hue_den) << SHIFT;
  assign sat_div = REM_W'(data_i.sat_den) << SHIFT;

  always_comb begin
    data_d = data_i;
    if (data_i.hue_rem >= hue_div) begin
      data_d.hue_rem = data_i.hue_rem - hue_div;
      data_d.hue_quo[SHIFT] = 1'b1;
    end
    if (data_i.sat_rem >= sat_div) begin
      data_d.sat_rem = data_i.sat_rem - sat_div;
      data_d.sat_quo[SHIFT] = 1'b1;
    end
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

FILE: hdl/hsv_tail.sv
module hsv_tail (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  hsv_pkg::hsv_cell_t        data_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [hsv_pkg::HUE_W-1:0] hue_o,
  output logic [hsv_pkg::SAT_W-1:0] sat_o,
  output logic [hsv_pkg::RGB_W-1:0] value_o
);
  import hsv_pkg::*;

  logic             valid_q, valid_d;
  logic [HUE_W-1:0] hue_q, hue_d, quo_ceil;
  logic [SAT_W-1:0] sat_q;
  logic [RGB_W-1:0] value_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    // negative terms floor towards minus infinity: subtract the ceiling
    quo_ceil = HUE_W'(data_i.hue_quo) + HUE_W'(data_i.hue_rem != '0);
    hue_d = data_i.hue_neg ? data_i.hue_base - quo_ceil
                           : data_i.hue_base + HUE_W'(data_i.hue_quo);
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hue_q <= hue_d;
      sat_q <= SAT_W'(data_i.sat_quo);
      value_q <= data_i.value;
    end
  end

  assign valid_o = valid_q;
  assign hue_o = hue_q;
  assign sat_o = sat_q;
  assign value_o = value_q;

endmodule

FILE: hdl/rgb_to_hsv_converter.sv
// RGB to HSV converter for pixel streams. One pixel word in, one HSV word out,
// a new pixel accepted in every clock cycle unless the output stalls. An input
// stage finds max, min and the hue sextant, a chain of 13 divider cells works
// out one quotient bit each for hue and saturation, and an output register
// applies the hue base and the floor correction. Hue is in 1/16 degree
// (0..5759), saturation is Q12 (0..4096), value is the largest component.
// Each stage holds its word under back-pressure and fills bubbles ahead of it.
module rgb_to_hsv_converter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  input  logic [hsv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [12:0] hue, [25:13] saturation, [33:26] brightness, [39:34] zero
  output logic [hsv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import hsv_pkg::*;

  logic      valid_c [QUO_W+1];
  logic      ready_c [QUO_W+1];
  hsv_cell_t data_c  [QUO_W+1];

  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] sat;
  logic [RGB_W-1:0] value;

  hsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .data_o  (data_c[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    hsv_div_cell #(
      .SHIFT (QUO_W - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .ready_o (ready_c[i]),
      .data_i  (data_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (ready_c[i+1]),
      .data_o  (data_c[i+1])
    );
  end

  hsv_tail u_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[QUO_W]),
    .ready_o (ready_c[QUO_W]),
    .data_i  (data_c[QUO_W]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .hue_o   (hue),
    .sat_o   (sat),
    .value_o (value)
  );

  assign m_axis_tdata = {6'b0, value, sat, hue};

endmodule

FILE: hdl/hsv_checker.sv
module hsv_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [hsv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [hsv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import hsv_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty pipeline");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:0] < 13'd5760 && m_axis_tdata[25:13] <= 13'd4096
      && m_axis_tdata[39:34] == 6'd0)
    else $error("hue or saturation out of range");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33:26] == 8'd0 |->
      m_axis_tdata[25:13] == 13'd0 && m_axis_tdata[12:0] == 13'd0)
    else $error("black pixel with non-zero hue or saturation");

endmodule

bind rgb_to_hsv_converter hsv_checker u_hsv_checker (.*);
